// ----- rtl/plidd_pkg.sv -----
// shared types and codes for the positional list block
package plidd_pkg;

    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_BACK  = 2'd1,
        FUNC_REMOVE     = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DUMP
    } state_t;

endpackage

// ----- rtl/plidd_store.sv -----
// entry store: one write port, one read port, registered read data
module plidd_store #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [plidd_pkg::VALUE_W-1:0] wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [plidd_pkg::VALUE_W-1:0] rdata
);

    logic [plidd_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/positional_list_insert_delete_dump.sv -----
// positional list: front insert, back append, indexed removal, full dump
//
// Input channel (in_valid/in_ready) takes one request: func, value, position.
// in_ready is high only while no request is in work; one request at a time.
// Output channel (out_valid/out_ready) returns the whole list front to back,
// one transaction per entry, is_last on the final one; an empty list gives a
// single transaction with list_empty and is_last set and item_value zero.
// Every transaction of a request carries the same status code.
// An insert writes the store in the accept cycle; a removal at position p of n
// entries first moves the n-1-p entries behind it, one per cycle while the output
// register is free, through the single read port and the single write port of
// the store. The dump reads one entry per cycle while the receiver does not stall.
// The store's registered read data is the output register: a stalled
// receiver holds it, and no further read is issued until it is taken.
// The next request may be taken while the last result still waits.
// Reset empties the list (front and count cleared); store contents are not
// cleared, since only entries inside the list are ever read.
module positional_list_insert_delete_dump #(
    parameter int CAPACITY = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [plidd_pkg::FUNC_W-1:0]          func,
    input  logic signed [plidd_pkg::VALUE_W-1:0]  value,
    input  logic [plidd_pkg::POS_W-1:0]           position,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [plidd_pkg::VALUE_W-1:0]  item_value,
    output logic                                  is_last,
    output logic                                  list_empty,
    output logic [plidd_pkg::STATUS_W-1:0]        status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > plidd_pkg::POS_W) ? CW : plidd_pkg::POS_W;

    plidd_pkg::state_t  state_reg, state_next;
    plidd_pkg::status_t status_reg, status_next;
    plidd_pkg::status_t out_status_reg, out_status_next;
    logic [AW-1:0]      front_reg, front_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic               last_reg, last_next;
    logic               empty_reg, empty_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;

    logic                          mem_we, mem_re;
    logic [AW-1:0]                 mem_waddr, mem_raddr;
    logic [plidd_pkg::VALUE_W-1:0] mem_wdata, mem_rdata;
    logic                          out_free;
    logic [CW-1:0]                 shift_start;

    // circular index: both operands below CAPACITY
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (AW+1)'(CAPACITY))
        begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    plidd_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= plidd_pkg::ST_IDLE;
            status_reg     <= plidd_pkg::STATUS_DONE;
            out_status_reg <= plidd_pkg::STATUS_DONE;
            front_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
            empty_reg      <= 1'b0;
            wr_pend_reg    <= 1'b0;
            wr_addr_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            status_reg     <= status_next;
            out_status_reg <= out_status_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
            empty_reg      <= empty_next;
            wr_pend_reg    <= wr_pend_next;
            wr_addr_reg    <= wr_addr_next;
        end
    end

    assign shift_start = CW'(position) + CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        out_status_next = out_status_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        empty_next      = empty_reg;
        wr_pend_next    = 1'b0;
        wr_addr_next    = wr_addr_reg;
        out_free        = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = (state_reg == plidd_pkg::ST_IDLE);

        // moved entry is written in the cycle after its read
        mem_we    = wr_pend_reg;
        mem_waddr = wr_addr_reg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = slot(front_reg, idx_reg[AW-1:0]);

        unique case (state_reg)
            plidd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = plidd_pkg::STATUS_DONE;
                    state_next  = plidd_pkg::ST_DUMP;
                    idx_next    = '0;
                    if (func == plidd_pkg::FUNC_PUSH_FRONT || func == plidd_pkg::FUNC_PUSH_BACK)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            status_next = plidd_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_wdata  = value;
                            count_next = count_reg + CW'(1);
                            if (func == plidd_pkg::FUNC_PUSH_FRONT)
                            begin
                                mem_waddr  = slot(front_reg, AW'(CAPACITY - 1));
                                front_next = slot(front_reg, AW'(CAPACITY - 1));
                            end
                            else
                            begin
                                mem_waddr = slot(front_reg, count_reg[AW-1:0]);
                            end
                        end
                    end
                    else if (func == plidd_pkg::FUNC_REMOVE)
                    begin
                        if (XW'(position) >= XW'(count_reg))
                        begin
                            status_next = plidd_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            if (position == '0)
                            begin
                                front_next = slot(front_reg, AW'(1));
                            end
                            else if (shift_start < count_reg)
                            begin
                                idx_next   = shift_start;
                                state_next = plidd_pkg::ST_SHIFT;
                            end
                        end
                    end
                end
            end

            plidd_pkg::ST_SHIFT:
            begin
                // read port feeds the output register, so wait for it to drain
                if (out_free)
                begin
                    mem_re       = 1'b1;
                    wr_pend_next = 1'b1;
                    wr_addr_next = slot(front_reg, idx_reg[AW-1:0] - AW'(1));
                    if (idx_reg == count_reg)
                    begin
                        idx_next   = '0;
                        state_next = plidd_pkg::ST_DUMP;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end

            plidd_pkg::ST_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (count_reg == '0)
                    begin
                        empty_next = 1'b1;
                        last_next  = 1'b1;
                        state_next = plidd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        empty_next = 1'b0;
                        last_next  = (idx_reg + CW'(1) == count_reg);
                        idx_next   = idx_reg + CW'(1);
                        if (idx_reg + CW'(1) == count_reg)
                        begin
                            state_next = plidd_pkg::ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = plidd_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign item_value = empty_reg ? '0 : mem_rdata;
    assign is_last    = last_reg;
    assign list_empty = empty_reg;
    assign status     = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re && (mem_waddr == mem_raddr)))
        else $error("read and write of the same slot in one cycle");

    a_read_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (!out_valid_reg || out_ready))
        else $error("store read would overwrite a waiting result");

    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> $past(mem_re && state_reg == plidd_pkg::ST_SHIFT))
        else $error("shift write without a shift read");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |-> last_reg)
        else $error("empty marker on a transaction that is not the last");

endmodule
